/* hdl/record_sort_by_key_unit_defines.svh */
// assertion macros used by the record sorter engine
`ifndef RECORD_SORT_BY_KEY_UNIT_DEFINES_SVH
`define RECORD_SORT_BY_KEY_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define RSBK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define RSBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rsbk_pkg.sv */
// types and constants of the record sorter
`default_nettype none

package rsbk_pkg;

  localparam int KEY_W       = 31;
  localparam int TAG_W       = 16;
  localparam int DATA_W      = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
  } rsbk_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rsbk_entry_t;

endpackage

`default_nettype wire

/* hdl/record_sort_by_key_unit.sv */
// Record sorter: records (31-bit key, 16-bit tag) stream in and are kept in ascending key order
// by an insertion sort over an on-chip record memory of MAX_ITEMS entries; the beat with tlast
// closes the batch and the whole batch then streams out in ascending key order, equal keys in
// arrival order, the final beat with tlast set. Records past MAX_ITEMS in one batch are dropped
// and every output beat of that batch carries tuser = 1. A four-entry input queue takes beats
// while the engine works. Storing one record moves each held record with a larger key up one entry,
// one entry per cycle through the memory; emission reads each record through the registered memory
// read (S_EMIT_RD, then S_EMIT_LD) and holds while the output register is not free.
`default_nettype none

module record_sort_by_key_unit
  import rsbk_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // sort_key[30:0], record_tag[46:31], zero pad
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // out_key[30:0], out_tag[46:31], zero pad
  output logic                   out_tlast,
  output logic                   out_tuser   // dropped
);

  rsbk_item_t       in_item;
  rsbk_item_t       pop_item;
  logic             pop_valid, pop_ready;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;

  assign in_item = '{key: in_tdata[KEY_W-1:0], tag: in_tdata[KEY_W+TAG_W-1:KEY_W],
                     last: in_tlast};

  rsbk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  rsbk_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_key     (out_key),
    .out_tag     (out_tag),
    .out_last    (out_tlast),
    .out_dropped (out_tuser)
  );

  assign out_tdata = {{(DATA_W-KEY_W-TAG_W){1'b0}}, out_tag, out_key};

endmodule

`default_nettype wire

/* hdl/rsbk_front.sv */
// input beat acceptance and the short queue in front of the sort engine
`default_nettype none

module rsbk_front
  import rsbk_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire rsbk_item_t in_item,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output rsbk_item_t      pop_item
);

  rsbk_item_t        q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ready  = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/rsbk_back.sv */
// insertion sort engine with record memory and output register
`default_nettype none

`include "record_sort_by_key_unit_defines.svh"

module rsbk_back
  import rsbk_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  wire rsbk_item_t pop_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [KEY_W-1:0] out_key,
  output logic [TAG_W-1:0] out_tag,
  output logic            out_last,
  output logic            out_dropped
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_PLACE   = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  rsbk_entry_t mem [MAX_ITEMS];

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  rsbk_item_t       cur_r, cur_nxt;
  rsbk_entry_t      rd_r;
  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_drop_r, out_drop_nxt;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  rsbk_entry_t      wdata;
  logic             out_free;
  logic             emit_last;
  rsbk_entry_t      new_entry;

  assign pop_ready   = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign emit_last   = (CW'(idx_r) + CW'(1)) == fill_r;
  assign new_entry   = '{key: cur_r.key, tag: cur_r.tag};
  assign out_valid   = out_valid_r;
  assign out_key     = out_key_r;
  assign out_tag     = out_tag_r;
  assign out_last    = out_last_r;
  assign out_dropped = out_drop_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = new_entry;
    re            = 1'b0;
    raddr         = pos_r - AW'(1);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          cur_nxt = pop_item;
          if (fill_r == CW'(MAX_ITEMS)) begin
            // store full: drop the record, still close the batch on its last flag
            ovf_nxt = 1'b1;
            if (pop_item.last) begin
              idx_nxt   = '0;
              state_nxt = S_EMIT_RD;
            end
          end else begin
            pos_nxt   = AW'(fill_r);
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          fill_nxt  = fill_r + CW'(1);
          idx_nxt   = '0;
          state_nxt = cur_r.last ? S_EMIT_RD : S_IDLE;
        end else begin
          re        = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // rd_r holds the entry just below pos_r
        if (rd_r.key > cur_r.key) begin
          we      = 1'b1;
          wdata   = rd_r;
          pos_nxt = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            re    = 1'b1;
            raddr = pos_r - AW'(2);
          end
        end else begin
          we        = 1'b1;
          fill_nxt  = fill_r + CW'(1);
          idx_nxt   = '0;
          state_nxt = cur_r.last ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PLACE: begin
        we        = 1'b1;
        fill_nxt  = fill_r + CW'(1);
        idx_nxt   = '0;
        state_nxt = cur_r.last ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        re        = 1'b1;
        raddr     = idx_r;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = rd_r.key;
          out_tag_nxt   = rd_r.tag;
          out_last_nxt  = emit_last;
          out_drop_nxt  = ovf_r;
          if (emit_last) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    out_key_r  <= out_key_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  `RSBK_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(MAX_ITEMS), "fill count beyond capacity")
  `RSBK_ASSERT_NOW(a_emit_nonempty, state_r == S_EMIT_RD, fill_r != '0, "emission with empty store")
  `RSBK_ASSERT_NOW(a_cmp_pos, state_r == S_CMP, pos_r != '0, "compare step at position zero")
  `RSBK_ASSERT_NEXT(a_clear_after_last, state_r == S_EMIT_LD && out_free && emit_last,
                    fill_r == '0 && ovf_r == 1'b0 && out_last_r, "batch not cleared after last")

endmodule

`default_nettype wire
